>>> sv/rrsg_pkg.sv
// ----------------------------------------------------------------------------
// rrsg_pkg
// Shared types and constants for the rounded rectangle span generator.
// ----------------------------------------------------------------------------
package rrsg_pkg;

	localparam int COORD_W        = 16;
	localparam int REQ_RADIUS_W   = 5;
	localparam int MAX_RADIUS_DEF = 31;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic        [COORD_W-1:0] extent_t;
	typedef logic   [REQ_RADIUS_W-1:0] req_radius_t;

endpackage

>>> sv/rrsg_if.sv
// ----------------------------------------------------------------------------
// rrsg_if
// Valid/ready channels: rectangle words in, span words out.
// ----------------------------------------------------------------------------
interface rrsg_rect_if;
	import rrsg_pkg::*;

	logic        valid;
	logic        ready;
	coord_t      rect_x;
	coord_t      rect_y;
	coord_t      rect_w;
	coord_t      rect_h;
	req_radius_t corner_radius;

	modport source (output valid, rect_x, rect_y, rect_w, rect_h, corner_radius,
		input ready);
	modport sink (input valid, rect_x, rect_y, rect_w, rect_h, corner_radius,
		output ready);
endinterface

interface rrsg_span_if;
	import rrsg_pkg::*;

	logic    valid;
	logic    ready;
	coord_t  span_x;
	coord_t  span_y;
	extent_t span_width;
	extent_t span_height;
	logic    run_last;

	modport source (output valid, span_x, span_y, span_width, span_height, run_last,
		input ready);
	modport sink (input valid, span_x, span_y, span_width, span_height, run_last,
		output ready);
endinterface

>>> sv/rounded_rect_span_generator.sv
// ----------------------------------------------------------------------------
// rounded_rect_span_generator
// Breaks a rounded rectangle into one-pixel corner spans plus a middle block.
// ----------------------------------------------------------------------------
// One rectangle word is taken at a time; the block drops ready until the run
// ends. A run gives 2*r corner spans (top then bottom for each corner row) and
// the middle block, flagged with run_last, where r is the clamped radius, at
// most MAX_RADIUS. An empty rectangle (width or height not positive) gives
// nothing and the block stays ready. The inset of each row is found by a small
// sequencer around a single squarer: the search walks the inset down from the
// previous row's value.
module rounded_rect_span_generator #(
	parameter int MAX_RADIUS = rrsg_pkg::MAX_RADIUS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	rrsg_rect_if.sink     rect,
	rrsg_span_if.source   span
);
	import rrsg_pkg::*;

	localparam int RW   = $clog2(MAX_RADIUS + 1);
	localparam int OP_W = RW + 1;
	localparam int SQ_W = 2 * OP_W;
	localparam logic [REQ_RADIUS_W-1:0] MAX_R_REQ = REQ_RADIUS_W'(MAX_RADIUS);

	typedef enum logic [3:0] {
		S_IDLE, S_CLAMP_H, S_CLAMP_W, S_SETUP, S_LIM, S_SEARCH, S_TOP, S_BOT, S_MID
	} state_t;

	state_t          state_q;
	coord_t          x_q, y_q;
	extent_t         w_q, h_q;
	logic [RW-1:0]   r_q, k_q, i_q;
	logic [SQ_W-1:0] r4sq_q, lim_q;

	logic            out_valid_q;
	coord_t          out_x_q, out_y_q;
	extent_t         out_w_q, out_h_q;
	logic            out_last_q;

	logic [OP_W-1:0] sq_op;
	logic [SQ_W-1:0] sq;
	logic [RW-1:0]   e_next;
	logic [RW-1:0]   r_minus_i;
	logic [RW-1:0]   req_r;
	extent_t         two_r;
	extent_t         two_k;
	logic            out_free;
	logic            emit;
	logic            accept;

	rrsg_square #(.OP_W(OP_W)) u_square (.op(sq_op), .sq(sq));

	assign r_minus_i = r_q - i_q;
	// only used while k is nonzero, so r-k+1 never exceeds r
	assign e_next    = r_q - k_q + RW'(1);
	assign two_r     = COORD_W'({r_q, 1'b0});
	assign two_k     = COORD_W'({k_q, 1'b0});
	assign req_r     = (rect.corner_radius > MAX_R_REQ) ? RW'(MAX_RADIUS)
	                                                    : rect.corner_radius[RW-1:0];
	assign out_free  = !out_valid_q || span.ready;
	assign emit      = out_free &&
	                   (state_q == S_TOP || state_q == S_BOT || state_q == S_MID);
	assign accept    = rect.valid && rect.ready;

	// Squarer operand: (2r) at setup, (2(r-i)-1) for the row limit,
	// and 2*(r-k+1) when testing one step lower inset.
	always_comb begin
		case (state_q)
			S_SETUP: sq_op = {r_q, 1'b0};
			S_LIM:   sq_op = {r_minus_i, 1'b0} - OP_W'(1);
			default: sq_op = {e_next, 1'b0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (span.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						x_q <= rect.rect_x;
						y_q <= rect.rect_y;
						w_q <= extent_t'(rect.rect_w);
						h_q <= extent_t'(rect.rect_h);
						r_q <= req_r;
						// drop empty rectangles right away
						if (!rect.rect_w[COORD_W-1] && rect.rect_w != '0 &&
							!rect.rect_h[COORD_W-1] && rect.rect_h != '0) begin
							state_q <= S_CLAMP_H;
						end
					end
				end
				S_CLAMP_H: begin
					if (two_r > h_q) begin
						r_q <= h_q[RW:1];
					end
					state_q <= S_CLAMP_W;
				end
				S_CLAMP_W: begin
					if (two_r > w_q) begin
						r_q <= w_q[RW:1];
					end
					state_q <= S_SETUP;
				end
				S_SETUP: begin
					r4sq_q  <= sq;
					i_q     <= '0;
					k_q     <= r_q;
					state_q <= (r_q == '0) ? S_MID : S_LIM;
				end
				S_LIM: begin
					lim_q   <= r4sq_q - sq;
					state_q <= S_SEARCH;
				end
				S_SEARCH: begin
					// advance the inset down while the next smaller one still fits
					if (k_q != '0 && sq <= lim_q) begin
						k_q <= k_q - RW'(1);
					end else begin
						state_q <= S_TOP;
					end
				end
				S_TOP: begin
					if (out_free) begin
						out_x_q     <= x_q + coord_t'(k_q);
						out_y_q     <= y_q + coord_t'(i_q);
						out_w_q     <= w_q - two_k;
						out_h_q     <= extent_t'(1);
						out_last_q  <= 1'b0;
						state_q     <= S_BOT;
					end
				end
				S_BOT: begin
					if (out_free) begin
						out_x_q     <= x_q + coord_t'(k_q);
						out_y_q     <= y_q + coord_t'(h_q) - coord_t'(1) - coord_t'(i_q);
						out_w_q     <= w_q - two_k;
						out_h_q     <= extent_t'(1);
						out_last_q  <= 1'b0;
						if (i_q == r_q - RW'(1)) begin
							state_q <= S_MID;
						end else begin
							i_q     <= i_q + RW'(1);
							state_q <= S_LIM;
						end
					end
				end
				S_MID: begin
					if (out_free) begin
						out_x_q     <= x_q;
						out_y_q     <= y_q + coord_t'(r_q);
						out_w_q     <= w_q;
						out_h_q     <= h_q - two_r;
						out_last_q  <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rect.ready       = (state_q == S_IDLE);
	assign span.valid       = out_valid_q;
	assign span.span_x      = out_x_q;
	assign span.span_y      = out_y_q;
	assign span.span_width  = out_w_q;
	assign span.span_height = out_h_q;
	assign span.run_last    = out_last_q;

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !rect.rect_w[COORD_W-1] && rect.rect_w != '0 &&
		 !rect.rect_h[COORD_W-1] && rect.rect_h != '0) |=> !rect.ready)
		else $error("rectangle word accepted but block stayed ready");

	a_radius_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (r_q <= RW'(MAX_RADIUS)))
		else $error("clamped radius above maximum");

	a_inset_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH || state_q == S_TOP || state_q == S_BOT)
		|-> (k_q <= r_q && i_q < r_q))
		else $error("inset or row index out of range");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MID && out_free) |=> (rect.ready && out_valid_q && out_last_q))
		else $error("middle block did not close the run");
`endif

endmodule

>>> sv/rrsg_square.sv
// ----------------------------------------------------------------------------
// rrsg_square
// Shared squarer used by the sequencer for every circle term.
// ----------------------------------------------------------------------------
module rrsg_square #(
	parameter int OP_W = 6
) (
	input  logic [OP_W-1:0]   op,
	output logic [2*OP_W-1:0] sq
);

	assign sq = (2*OP_W)'(op) * (2*OP_W)'(op);

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rounded rectangle span generator.
// ----------------------------------------------------------------------------
// Rectangle words go in over a valid/ready channel from a queue of pending
// items, and span words are checked in order against a local model of the
// corner inset search. A short directed list covers empty rectangles, radius
// clamping, zero radius, zero middle height and coordinate wrap. Random
// rectangles follow. Both sides idle in short bursts except near the end.
// ----------------------------------------------------------------------------
module tb_top;
	import rrsg_pkg::*;

	localparam int HALF_PERIOD  = 6;
	localparam int RESET_CYCLES = 7;
	localparam int RANDOM_RECTS = 165;
	localparam int CALM_TAIL    = 25;
	localparam int DRAIN_CYCLES = 400;
	localparam int IDLE_LIMIT   = 4000;
	localparam int SHOWN_ERRORS = 10;

	typedef struct packed {
		coord_t      x;
		coord_t      y;
		coord_t      w;
		coord_t      h;
		req_radius_t radius;
	} rect_word_t;

	typedef struct packed {
		coord_t  x;
		coord_t  y;
		extent_t width;
		extent_t height;
		logic    last;
	} span_word_t;

	logic clk = 1'b0;
	logic arst_n;

	rrsg_rect_if rect_ch ();
	rrsg_span_if span_ch ();

	rounded_rect_span_generator u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rect   (rect_ch.sink),
		.span   (span_ch.source)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	rect_word_t rect_pending_q[$];
	span_word_t span_expect_q[$];

	int rects_sent;
	int rects_empty;
	int spans_seen;
	int error_count;
	int idle_cycles;
	int rect_gap;
	int span_stall;

	// Least inset k such that 4(r-k)^2 <= 4r^2 - (2r-2i-1)^2.
	function automatic int corner_inset(int r, int i);
		int d;
		int lim;
		d   = 2 * r - 2 * i - 1;
		lim = 4 * r * r - d * d;
		for (int k = 0; k < r; k++) begin
			if (4 * (r - k) * (r - k) <= lim)
				return k;
		end
		return r;
	endfunction

	function automatic void predict_spans(rect_word_t rw);
		int x;
		int y;
		int w;
		int h;
		int r;
		int k;
		x = rw.x;
		y = rw.y;
		w = rw.w;
		h = rw.h;
		r = rw.radius;
		if (w <= 0 || h <= 0) begin
			rects_empty++;
			return;
		end
		if (r > MAX_RADIUS_DEF)
			r = MAX_RADIUS_DEF;
		if (2 * r > h)
			r = h / 2;
		if (2 * r > w)
			r = w / 2;
		for (int i = 0; i < r; i++) begin
			k = corner_inset(r, i);
			span_expect_q.push_back('{coord_t'(x + k), coord_t'(y + i),
				extent_t'(w - 2 * k), extent_t'(1), 1'b0});
			span_expect_q.push_back('{coord_t'(x + k), coord_t'(y + h - 1 - i),
				extent_t'(w - 2 * k), extent_t'(1), 1'b0});
		end
		span_expect_q.push_back('{coord_t'(x), coord_t'(y + r), extent_t'(w),
			extent_t'(h - 2 * r), 1'b1});
	endfunction

	function automatic string span_text(span_word_t s);
		return $sformatf("x=%0d y=%0d width=%0d height=%0d last=%0b",
			s.x, s.y, s.width, s.height, s.last);
	endfunction

	function automatic void note_error(string msg);
		error_count++;
		if (error_count <= SHOWN_ERRORS)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endfunction

	function automatic void add_rect(int x, int y, int w, int h, int r);
		rect_pending_q.push_back('{coord_t'(x), coord_t'(y), coord_t'(w), coord_t'(h),
			req_radius_t'(r)});
	endfunction

	// Mostly small extents so the radius clamp and full corners both show up.
	function automatic coord_t pick_extent();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 7)
			return coord_t'($urandom_range(1, 72));
		if (sel < 9)
			return coord_t'($urandom_range(1, 32767));
		return coord_t'($urandom());
	endfunction

	// Rectangle driver: advance to the next word once the current one is taken.
	always @(posedge clk or negedge arst_n) begin
		rect_word_t nxt;
		logic       load;
		if (!arst_n) begin
			rect_ch.valid         <= 1'b0;
			rect_ch.rect_x        <= '0;
			rect_ch.rect_y        <= '0;
			rect_ch.rect_w        <= '0;
			rect_ch.rect_h        <= '0;
			rect_ch.corner_radius <= '0;
			rect_gap              <= 0;
		end else begin
			load = 1'b0;
			if (rect_ch.valid && rect_ch.ready) begin
				rects_sent++;
				predict_spans('{rect_ch.rect_x, rect_ch.rect_y, rect_ch.rect_w,
					rect_ch.rect_h, rect_ch.corner_radius});
			end
			if (!rect_ch.valid || rect_ch.ready) begin
				if (rect_gap > 0) begin
					rect_gap <= rect_gap - 1;
				end else if (rect_pending_q.size() > 0) begin
					if (rect_pending_q.size() >= CALM_TAIL && $urandom_range(0, 5) == 0)
						rect_gap <= $urandom_range(0, 2);
					else
						load = 1'b1;
				end
				if (load) begin
					nxt = rect_pending_q.pop_front();
					rect_ch.rect_x        <= nxt.x;
					rect_ch.rect_y        <= nxt.y;
					rect_ch.rect_w        <= nxt.w;
					rect_ch.rect_h        <= nxt.h;
					rect_ch.corner_radius <= nxt.radius;
				end
				rect_ch.valid <= load;
			end
		end
	end

	// Span monitor: check each accepted word against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		span_word_t want;
		span_word_t got;
		if (!arst_n) begin
			span_ch.ready <= 1'b0;
			span_stall    <= 0;
		end else begin
			if (span_ch.valid && span_ch.ready) begin
				spans_seen++;
				got = '{span_ch.span_x, span_ch.span_y, span_ch.span_width,
					span_ch.span_height, span_ch.run_last};
				if (span_expect_q.size() == 0) begin
					note_error($sformatf("span %0d not expected: %s", spans_seen,
						span_text(got)));
				end else begin
					want = span_expect_q.pop_front();
					if (got !== want)
						note_error($sformatf("span %0d expected %s, got %s", spans_seen,
							span_text(want), span_text(got)));
				end
			end
			if (span_stall > 0) begin
				span_stall    <= span_stall - 1;
				span_ch.ready <= 1'b0;
			end else if (rect_pending_q.size() >= CALM_TAIL && $urandom_range(0, 4) == 0) begin
				span_stall    <= $urandom_range(0, 2);
				span_ch.ready <= 1'b0;
			end else begin
				span_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (rect_ch.valid && rect_ch.ready) || (span_ch.valid && span_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		idle_cycles = 0;
		do @(posedge clk); while (idle_cycles < IDLE_LIMIT);
		$display("no word moved for %0d cycles, %0d spans still expected", IDLE_LIMIT,
			span_expect_q.size());
		$display("FAIL");
		$finish;
	end

	initial begin
		int nonempty;
		rect_word_t rw;
		rects_sent  = 0;
		rects_empty = 0;
		spans_seen  = 0;
		error_count = 0;
		arst_n <= 1'b0;

		// empty rectangles, both extents at the negative limit and at zero
		add_rect(10, 20, 0, 50, 4);
		add_rect(10, 20, 50, 0, 4);
		add_rect(-32768, 32767, -32768, 40, 31);
		add_rect(32767, -32768, 40, -32768, 31);
		add_rect(0, 0, -1, -1, 0);
		// zero radius, and a radius clamped down to zero
		add_rect(5, 6, 30, 20, 0);
		add_rect(100, 100, 1, 1, 31);
		add_rect(-7, 3, 32767, 1, 5);
		// full radius, then clamp by odd and even height, then by width
		add_rect(0, 0, 100, 100, 31);
		add_rect(1, 2, 80, 7, 31);
		add_rect(-3, -4, 80, 10, 31);
		add_rect(40, 50, 9, 200, 20);
		add_rect(0, 0, 2, 2, 1);
		add_rect(-100, 200, 3, 3, 2);
		add_rect(12, 34, 62, 62, 31);
		add_rect(12, 34, 61, 64, 31);
		// coordinates and sums that wrap around 16 bits
		add_rect(32767, 32767, 32767, 32767, 31);
		add_rect(-32768, -32768, 40, 40, 17);
		add_rect(32760, 32700, 100, 90, 12);
		add_rect(-1, -1, 65, 33, 16);

		nonempty = 0;
		while (nonempty < RANDOM_RECTS) begin
			rw.x      = coord_t'($urandom());
			rw.y      = coord_t'($urandom());
			rw.w      = pick_extent();
			rw.h      = pick_extent();
			rw.radius = req_radius_t'($urandom_range(0, 31));
			rect_pending_q.push_back(rw);
			if (rw.w > 0 && rw.h > 0)
				nonempty++;
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (rect_pending_q.size() > 0 || rect_ch.valid)
			@(posedge clk);
		while (span_expect_q.size() > 0)
			@(posedge clk);
		// empty rectangles give no word, so let any stray output show up
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("rectangles sent: %0d (%0d empty), span words checked: %0d",
			rects_sent, rects_empty, spans_seen);
		$display("mismatches: %0d", error_count);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
